// ----- src/sacl_pkg.sv -----
// Shared types and constants of the set-associative cache tag array.
`timescale 1ns / 1ps

package sacl_pkg;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 4;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BITS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WAYS_USED   = 2'd2;

  localparam logic [CFG_DATA_W-1:0] OFFSET_BITS_RST = 4'd6;
  localparam logic [CFG_DATA_W-1:0] SET_BITS_RST    = 4'd6;
  localparam logic [CFG_DATA_W-1:0] WAYS_USED_RST   = 4'd4;

  localparam int ADDR_W = 32;
  localparam int TAG_W  = 32;
  localparam int CNT_W  = 32;

  // Request kinds.
  localparam logic REQ_ACCESS = 1'b0;
  localparam logic REQ_INVAL  = 1'b1;

  typedef struct packed {
    logic              req_type;
    logic [ADDR_W-1:0] address;
  } in_item_t;

  typedef struct packed {
    logic             hit;
    logic [CNT_W-1:0] hit_count;
    logic [CNT_W-1:0] miss_count;
  } out_item_t;

endpackage

// ----- src/sacl_ram.sv -----
// Single-port-write, registered-read memory holding one row per set.
`timescale 1ns / 1ps

module sacl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- src/sacl_lookup.sv -----
// Parallel tag compare and victim selection over the ways of one set.
`timescale 1ns / 1ps

module sacl_lookup #(
  parameter int MAX_WAYS = 8,
  parameter int RW       = 3,
  parameter int WW       = 3,
  parameter int NWW      = 4
) (
  input  logic [MAX_WAYS-1:0]                    valid,
  input  logic [MAX_WAYS-1:0][RW-1:0]            rank,
  input  logic [MAX_WAYS-1:0][sacl_pkg::TAG_W-1:0] tags,
  input  logic [sacl_pkg::TAG_W-1:0]             tag,
  input  logic [NWW-1:0]                         nw,
  output logic                                   hit,
  output logic [WW-1:0]                          hit_way,
  output logic [WW-1:0]                          victim
);
  import sacl_pkg::*;

  logic          any_free;
  logic [WW-1:0] free_way;
  logic [WW-1:0] lru_way;

  // Scanning downwards lets the lowest matching way win.
  always_comb begin
    hit      = 1'b0;
    hit_way  = '0;
    any_free = 1'b0;
    free_way = '0;
    for (int i = MAX_WAYS - 1; i >= 0; i--) begin
      if (i < int'(nw)) begin
        if (valid[i] && tags[i] == tag) begin
          hit     = 1'b1;
          hit_way = WW'(i);
        end
        if (!valid[i]) begin
          any_free = 1'b1;
          free_way = WW'(i);
        end
      end
    end
  end

  // Least rank among the ways in use; a strict compare keeps the lowest way on a tie.
  always_comb begin
    lru_way = '0;
    for (int i = 1; i < MAX_WAYS; i++) begin
      if (i < int'(nw) && rank[i] < rank[lru_way]) begin
        lru_way = WW'(i);
      end
    end
  end

  assign victim = any_free ? free_way : lru_way;

endmodule

// ----- src/set_assoc_lru_cache_tags.sv -----
// Top level of the set-associative cache tag array with true LRU replacement.
//
//  Channel  Direction  Handshake          Payload
//  in_      input      in_valid/in_stall  in_item  (req_type, address)
//  out_     output     out_valid/out_stall out_item (hit, hit_count, miss_count)
//  cfg_     input      cfg_we             cfg_index, cfg_wdata
//
// An item is handled in order: the accept edge reads the set's row from the row memory,
// the compare state compares tags and picks the way, and the write-back state writes
// the row back and loads the result register. Items are taken only in the idle state.
// After reset a clearing pass writes every one of the MAX_SETS rows, one per cycle,
// before the first item is accepted; configuration writes are taken throughout.
// A stalled result holds the write-back cycle; a new item is accepted while the
// previous result still waits in the output register.
`timescale 1ns / 1ps

module set_assoc_lru_cache_tags #(
  parameter int MAX_WAYS   = 8,
  parameter int MAX_SETS   = 256,
  parameter int ADDR_WIDTH = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  sacl_pkg::in_item_t                in_item,
  output logic                              out_valid,
  input  logic                              out_stall,
  output sacl_pkg::out_item_t               out_item,
  input  logic                              cfg_we,
  input  logic [sacl_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [sacl_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import sacl_pkg::*;

  localparam int RW     = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int WW     = RW;
  localparam int NWW    = $clog2(MAX_WAYS + 1);
  localparam int SIW    = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
  localparam int SB_MAX = $clog2(MAX_SETS + 1) - 1;
  localparam int AW_EFF = (ADDR_WIDTH < ADDR_W) ? ADDR_WIDTH : ADDR_W;
  localparam logic [ADDR_W-1:0] ADDR_MASK =
    (AW_EFF >= ADDR_W) ? {ADDR_W{1'b1}} : ADDR_W'((64'd1 << AW_EFF) - 64'd1);
  localparam int RANK_LO = MAX_WAYS;
  localparam int TAG_LO  = MAX_WAYS * (1 + RW);
  localparam int ROW_W   = MAX_WAYS * (1 + RW + TAG_W);
  localparam logic [RW-1:0]    MAX_RANK = RW'(MAX_WAYS - 1);
  localparam logic [SIW-1:0]   LAST_SET = SIW'(MAX_SETS - 1);
  localparam logic [CNT_W-1:0] CNT_MAX  = {CNT_W{1'b1}};

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CMP,
    ST_WB
  } state_t;

  state_t state_r;

  logic [CFG_DATA_W-1:0] off_r, setb_r, ways_r;
  logic [SIW-1:0]        clr_idx_r;
  logic                  req_r;
  logic [SIW-1:0]        set_r;
  logic [TAG_W-1:0]      tag_r;
  logic [NWW-1:0]        nw_r;
  logic                  hit_r;
  logic [WW-1:0]         way_r;
  logic [CNT_W-1:0]      hit_cnt_r, miss_cnt_r;
  logic [CNT_W-1:0]      hit_cnt_nxt, miss_cnt_nxt;
  logic                  out_valid_r;
  out_item_t             out_item_r;

  // Request decode from the input payload.
  logic [ADDR_W-1:0]     addr_m;
  logic [CFG_DATA_W-1:0] sb_eff;
  logic [4:0]            tag_sh;
  logic [ADDR_W-1:0]     set_full;
  logic [SIW-1:0]        set_in;
  logic [TAG_W-1:0]      tag_in;
  logic [NWW-1:0]        nw_in;
  logic                  in_acc;

  // Row memory signals.
  logic                  mem_we;
  logic [SIW-1:0]        mem_waddr;
  logic [ROW_W-1:0]      mem_wdata;
  logic [ROW_W-1:0]      mem_rdata;

  logic [MAX_WAYS-1:0]             rd_valid, new_valid;
  logic [MAX_WAYS-1:0][RW-1:0]     rd_rank, new_rank;
  logic [MAX_WAYS-1:0][TAG_W-1:0]  rd_tags, new_tags;

  logic                  lk_hit;
  logic [WW-1:0]         lk_hit_way, lk_victim;
  logic                  wb_go;

  always_comb begin
    addr_m   = in_item.address & ADDR_MASK;
    sb_eff   = ({1'b0, setb_r} > 5'(SB_MAX)) ? CFG_DATA_W'(SB_MAX) : setb_r;
    tag_sh   = {1'b0, off_r} + {1'b0, sb_eff};
    set_full = (addr_m >> off_r) & ~({ADDR_W{1'b1}} << sb_eff);
    set_in   = set_full[SIW-1:0];
    tag_in   = TAG_W'(addr_m >> tag_sh);
    if (ways_r == '0) begin
      nw_in = NWW'(1);
    end else if ({1'b0, ways_r} > 5'(MAX_WAYS)) begin
      nw_in = NWW'(MAX_WAYS);
    end else begin
      nw_in = NWW'(ways_r);
    end
  end

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign wb_go    = (state_r == ST_WB) && (!out_valid_r || !out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_r  <= OFFSET_BITS_RST;
      setb_r <= SET_BITS_RST;
      ways_r <= WAYS_USED_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_OFFSET_BITS: off_r  <= cfg_wdata;
        CFG_SET_BITS:    setb_r <= cfg_wdata;
        CFG_WAYS_USED:   ways_r <= cfg_wdata;
        default:         ;
      endcase
    end
  end

  sacl_ram #(
    .WIDTH (ROW_W),
    .DEPTH (MAX_SETS),
    .AW    (SIW)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (in_acc),
    .raddr (set_in),
    .rdata (mem_rdata)
  );

  assign rd_valid = mem_rdata[RANK_LO-1:0];
  assign rd_rank  = mem_rdata[TAG_LO-1:RANK_LO];
  assign rd_tags  = mem_rdata[ROW_W-1:TAG_LO];

  sacl_lookup #(
    .MAX_WAYS (MAX_WAYS),
    .RW       (RW),
    .WW       (WW),
    .NWW      (NWW)
  ) u_lookup (
    .valid   (rd_valid),
    .rank    (rd_rank),
    .tags    (rd_tags),
    .tag     (tag_r),
    .nw      (nw_r),
    .hit     (lk_hit),
    .hit_way (lk_hit_way),
    .victim  (lk_victim)
  );

  // Row update: an access touches the way it used, moving every way ranked above it
  // down by one; an invalidate only drops the valid bit.
  always_comb begin
    new_valid = rd_valid;
    new_rank  = rd_rank;
    new_tags  = rd_tags;
    if (req_r == REQ_INVAL) begin
      if (hit_r) begin
        new_valid[way_r] = 1'b0;
      end
    end else begin
      if (!hit_r) begin
        new_tags[way_r]  = tag_r;
        new_valid[way_r] = 1'b1;
      end
      for (int i = 0; i < MAX_WAYS; i++) begin
        if (WW'(i) != way_r && rd_rank[i] > rd_rank[way_r]) begin
          new_rank[i] = rd_rank[i] - RW'(1);
        end
      end
      new_rank[way_r] = MAX_RANK;
    end
  end

  always_comb begin
    hit_cnt_nxt  = hit_cnt_r;
    miss_cnt_nxt = miss_cnt_r;
    if (req_r == REQ_ACCESS) begin
      if (hit_r && hit_cnt_r != CNT_MAX) begin
        hit_cnt_nxt = hit_cnt_r + CNT_W'(1);
      end
      if (!hit_r && miss_cnt_r != CNT_MAX) begin
        miss_cnt_nxt = miss_cnt_r + CNT_W'(1);
      end
    end
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = set_r;
    mem_wdata = {new_tags, new_rank, new_valid};
    if (state_r == ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_idx_r;
      mem_wdata = '0;
    end else if (wb_go) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_idx_r   <= '0;
      hit_cnt_r   <= '0;
      miss_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // A result taken in the same cycle as a write-back is replaced by the new one.
      if (out_valid_r && !out_stall && !wb_go) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_CLEAR: begin
          clr_idx_r <= clr_idx_r + SIW'(1);
          if (clr_idx_r == LAST_SET) begin
            state_r <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_acc) begin
            req_r   <= in_item.req_type;
            set_r   <= set_in;
            tag_r   <= tag_in;
            nw_r    <= nw_in;
            state_r <= ST_CMP;
          end
        end
        ST_CMP: begin
          hit_r   <= lk_hit;
          way_r   <= lk_hit ? lk_hit_way : lk_victim;
          state_r <= ST_WB;
        end
        ST_WB: begin
          if (wb_go) begin
            hit_cnt_r             <= hit_cnt_nxt;
            miss_cnt_r            <= miss_cnt_nxt;
            out_valid_r           <= 1'b1;
            out_item_r.hit        <= hit_r;
            out_item_r.hit_count  <= hit_cnt_nxt;
            out_item_r.miss_count <= miss_cnt_nxt;
            state_r               <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // A result appears only out of the write-back cycle.
  a_out_from_wb: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_WB))
    else $error("result raised outside write-back");

  // The row memory is not written while the tags are being compared.
  a_no_write_in_cmp: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CMP) |-> !mem_we)
    else $error("row write during compare");

  // No result is offered while the clearing pass runs.
  a_quiet_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR) |-> !out_valid_r)
    else $error("result during clearing pass");

  // An invalidate leaves both counters alone.
  a_inval_counts: assert property (@(posedge clk) disable iff (!rst_n)
    (wb_go && req_r == REQ_INVAL) |=>
      (hit_cnt_r == $past(hit_cnt_r) && miss_cnt_r == $past(miss_cnt_r)))
    else $error("invalidate changed a counter");

endmodule

// ----- bench/set_assoc_lru_cache_tags_tb.sv -----
// Self-checking testbench for the set-associative LRU cache tag array.
`timescale 1ns / 1ps

module set_assoc_lru_cache_tags_tb;
  import sacl_pkg::*;

  localparam int N_WAYS     = 8;
  localparam int N_SETS     = 256;
  localparam int LOG_SETS   = 8;
  localparam int CYCLE_CAP  = 300000;
  localparam int PHASE_LEN  = 200;
  localparam int N_PHASES   = 10;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  in_item_t    in_item;
  logic        out_valid;
  logic        out_stall;
  out_item_t   out_item;
  logic        cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  bit calm;
  bit hold_request;
  int cycles;

  always #1 clk = ~clk;

  set_assoc_lru_cache_tags u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Tracks the tag array, its recency order and the counters, and holds the lookup
  // results still to arrive.
  class lru_tag_board;
    logic [31:0] tags [N_SETS*N_WAYS];
    bit          valid [N_SETS*N_WAYS];
    bit [2:0]    rank [N_SETS*N_WAYS];
    bit [31:0]   hits;
    bit [31:0]   misses;
    bit [3:0]    off_cfg;
    bit [3:0]    set_cfg;
    bit [3:0]    ways_cfg;
    out_item_t   awaited [$];
    int          errors;

    function new();
      foreach (valid[i]) begin
        valid[i] = 1'b0;
        rank[i] = '0;
      end
      hits = '0;
      misses = '0;
      off_cfg = OFFSET_BITS_RST;
      set_cfg = SET_BITS_RST;
      ways_cfg = WAYS_USED_RST;
      errors = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
      case (idx)
        CFG_OFFSET_BITS: off_cfg = v;
        CFG_SET_BITS:    set_cfg = v;
        CFG_WAYS_USED:   ways_cfg = v;
        default: ;
      endcase
    endfunction

    function int eff_set_bits();
      return (set_cfg > LOG_SETS) ? LOG_SETS : int'(set_cfg);
    endfunction

    function int eff_ways();
      if (ways_cfg == 0) return 1;
      return (ways_cfg > N_WAYS) ? N_WAYS : int'(ways_cfg);
    endfunction

    function logic [31:0] compose(logic [31:0] tag, int set_i, logic [31:0] low);
      bit [63:0] a;
      int off;
      int sb;
      off = off_cfg;
      sb = eff_set_bits();
      a = ({32'd0, tag} << (off + sb)) | (64'(set_i) << off) |
          ({32'd0, low} & ((64'd1 << off) - 1));
      return a[31:0];
    endfunction

    // Moves a way to the top of its set's recency order.
    function void promote(int base, int w);
      bit [2:0] r;
      r = rank[base+w];
      for (int i = 0; i < N_WAYS; i++)
        if (i != w && rank[base+i] > r) rank[base+i]--;
      rank[base+w] = 3'(N_WAYS - 1);
    endfunction

    function void note_request(in_item_t it);
      bit [63:0] a;
      int off, sb, nw, set_i, base, way, victim;
      bit [31:0] tag;
      bit found;
      out_item_t res;
      a = {32'd0, it.address};
      off = off_cfg;
      sb = eff_set_bits();
      nw = eff_ways();
      set_i = int'((a >> off) & ((64'd1 << sb) - 1));
      tag = 32'(a >> (off + sb));
      base = set_i * N_WAYS;
      found = 1'b0;
      way = 0;
      for (int i = 0; i < nw; i++) begin
        if (!found && valid[base+i] && tags[base+i] == tag) begin
          found = 1'b1;
          way = i;
        end
      end
      if (it.req_type == REQ_INVAL) begin
        if (found) valid[base+way] = 1'b0;
      end else if (found) begin
        if (hits != 32'hFFFF_FFFF) hits++;
        promote(base, way);
      end else begin
        if (misses != 32'hFFFF_FFFF) misses++;
        victim = nw;
        for (int i = nw - 1; i >= 0; i--)
          if (!valid[base+i]) victim = i;
        if (victim == nw) begin
          victim = 0;
          for (int i = 1; i < nw; i++)
            if (rank[base+i] < rank[base+victim]) victim = i;
        end
        tags[base+victim] = tag;
        valid[base+victim] = 1'b1;
        promote(base, victim);
      end
      res.hit = found;
      res.hit_count = hits;
      res.miss_count = misses;
      awaited.push_back(res);
    endfunction

    function void check_lookup(out_item_t got);
      out_item_t want;
      if (awaited.size() == 0) begin
        $error("unexpected lookup result: hit %0d, hit_count %0d, miss_count %0d",
               got.hit, got.hit_count, got.miss_count);
        errors++;
        return;
      end
      want = awaited.pop_front();
      if (got.hit !== want.hit) begin
        $error("hit: expected %0d, got %0d", want.hit, got.hit);
        errors++;
      end
      if (got.hit_count !== want.hit_count) begin
        $error("hit_count: expected %0d, got %0d", want.hit_count, got.hit_count);
        errors++;
      end
      if (got.miss_count !== want.miss_count) begin
        $error("miss_count: expected %0d, got %0d", want.miss_count, got.miss_count);
        errors++;
      end
    endfunction
  endclass

  lru_tag_board board;

  function bit roll_idle();
    return !calm && ($urandom_range(99) < 29);
  endfunction

  task send_item(in_item_t it);
    while (roll_idle()) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_request(it);
  endtask

  task wait_idle();
    in_valid <= 1'b0;
    while (board.awaited.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task load_config(logic [3:0] off_v, logic [3:0] set_v, logic [3:0] ways_v);
    cfg_we <= 1'b1;
    cfg_index <= CFG_OFFSET_BITS;
    cfg_wdata <= off_v;
    @(posedge clk);
    board.write_reg(CFG_OFFSET_BITS, off_v);
    cfg_index <= CFG_SET_BITS;
    cfg_wdata <= set_v;
    @(posedge clk);
    board.write_reg(CFG_SET_BITS, set_v);
    cfg_index <= CFG_WAYS_USED;
    cfg_wdata <= ways_v;
    @(posedge clk);
    board.write_reg(CFG_WAYS_USED, ways_v);
    cfg_we <= 1'b0;
  endtask

  // Runs under the reset settings: fill, hit, eviction, invalidate hit and miss,
  // refill of a freed way and the address extremes.
  task run_directed();
    in_item_t seq [$];
    in_item_t it;
    it.req_type = REQ_ACCESS; it.address = 32'h0000_0000; seq.push_back(it);
    seq.push_back(it);
    it.address = 32'hFFFF_FFFF; seq.push_back(it);
    it.req_type = REQ_INVAL; seq.push_back(it);
    seq.push_back(it);
    it.req_type = REQ_ACCESS;
    for (int t = 1; t <= 4; t++) begin
      it.address = board.compose(t, 5, t * 3);
      seq.push_back(it);
    end
    it.address = board.compose(1, 5, 63); seq.push_back(it);
    it.address = board.compose(5, 5, 0); seq.push_back(it);
    it.address = board.compose(2, 5, 0); seq.push_back(it);
    it.req_type = REQ_INVAL; it.address = board.compose(4, 5, 7); seq.push_back(it);
    it.address = board.compose(9, 5, 0); seq.push_back(it);
    it.req_type = REQ_ACCESS; it.address = board.compose(6, 5, 0); seq.push_back(it);
    it.address = board.compose(1, 5, 0); seq.push_back(it);
    it.address = board.compose(6, 5, 1); seq.push_back(it);
    it.address = 32'h7FFF_FFFF; seq.push_back(it);
    it.address = 32'h8000_0000; seq.push_back(it);
    it.address = 32'h5555_5555; seq.push_back(it);
    it.address = 32'hAAAA_AAAA; seq.push_back(it);
    it.address = 32'h8000_0000; seq.push_back(it);
    foreach (seq[i]) send_item(seq[i]);
    wait_idle();
  endtask

  // Mostly reuses a few sets and slightly more tags than ways, so that lines hit,
  // get evicted and get invalidated; the rest is random noise.
  task run_phase(int n_items, bit hold);
    logic [31:0] tag_pool [N_WAYS+2];
    int set_pool [4];
    int nw, sb;
    in_item_t it;
    nw = board.eff_ways();
    sb = board.eff_set_bits();
    foreach (tag_pool[i]) tag_pool[i] = $urandom();
    foreach (set_pool[i]) set_pool[i] = $urandom_range((1 << sb) - 1);
    for (int k = 0; k < n_items; k++) begin
      if (hold && k == n_items / 3) hold_request = 1'b1;
      if ($urandom_range(99) < 80) begin
        it.req_type = ($urandom_range(99) < 15) ? REQ_INVAL : REQ_ACCESS;
        it.address = board.compose(tag_pool[$urandom_range(nw + 1)],
                                   set_pool[$urandom_range(3)], $urandom());
      end else begin
        it.req_type = ($urandom_range(1) == 1) ? REQ_INVAL : REQ_ACCESS;
        it.address = $urandom();
      end
      send_item(it);
    end
    wait_idle();
  endtask

  // Result side: checks every accepted item and stalls at random, or for a long
  // stretch when asked to.
  initial begin
    int hold_left;
    hold_left = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) board.check_lookup(out_item);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left = 80;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= roll_idle();
      end
    end
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_CAP) begin
      @(posedge clk);
      cycles++;
    end
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    logic [3:0] plan [8][3];
    plan = '{'{4'd0, 4'd0, 4'd1}, '{4'd12, 4'd8, 4'd8}, '{4'd15, 4'd15, 4'd15},
             '{4'd0, 4'd0, 4'd0}, '{4'd3, 4'd2, 4'd2}, '{4'd12, 4'd0, 4'd9},
             '{4'd1, 4'd8, 4'd3}, '{4'd6, 4'd6, 4'd4}};
    board = new();
    calm = 1'b0;
    hold_request = 1'b0;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_item <= '0;
    cfg_we <= 1'b0;
    cfg_index <= CFG_OFFSET_BITS;
    cfg_wdata <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    run_directed();
    for (int p = 0; p < N_PHASES; p++) begin
      if (p < 8)
        load_config(plan[p][0], plan[p][1], plan[p][2]);
      else
        load_config(4'($urandom_range(15)), 4'($urandom_range(15)),
                    4'($urandom_range(15)));
      calm = (p == 4);
      run_phase(PHASE_LEN, p == 2 || p == 7);
    end
    if (board.errors == 0 && board.awaited.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
